FILE: rtl/tlbcr_pkg.sv
// Shared types and constants for the TLB lookup unit with clock replacement.
package tlbcr_pkg;

  localparam int PFN_W  = 20;
  localparam int SLOT_W = 4;
  localparam int HIT_W  = 32;

  typedef struct packed {
    logic capture;   // latch the incoming item
    logic lookup;    // compare tags, register search vectors
    logic read_mem;  // hit: read frame, set used/dirty, count
    logic fill;      // miss: install walker frame in victim
    logic load;      // load output registers
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;       // some valid entry matched
  } dp_status_t;

endpackage

FILE: rtl/tlbcr_ctrl.sv
// Controller state machine sequencing lookup, victim choice and result transfer.
module tlbcr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  tlbcr_pkg::dp_status_t status,
  output tlbcr_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_next = S_SEL;
      end
      S_SEL: begin
        cmd.read_mem = status.hit;
        cmd.fill     = ~status.hit;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

endmodule

FILE: rtl/tlbcr_dp.sv
// Datapath: tag match array, entry flags, clock victim search, frame memory, outputs.
module tlbcr_dp #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_BITS   = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tlbcr_pkg::ctrl_cmd_t              cmd,
  output tlbcr_pkg::dp_status_t             status,
  input  logic [PAGE_BITS-1:0]              vpn,
  input  logic                              write,
  input  logic [PAGE_BITS-1:0]              walk_pfn,
  output logic [tlbcr_pkg::PFN_W-1:0]       pfn,
  output logic                              hit,
  output logic [tlbcr_pkg::SLOT_W-1:0]      slot,
  output logic [tlbcr_pkg::HIT_W-1:0]       hit_total
);

  localparam int IDX_W = $clog2(TLB_ENTRIES);
  localparam logic [TLB_ENTRIES-1:0] ONE = {{(TLB_ENTRIES-1){1'b0}}, 1'b1};

  function automatic logic [IDX_W-1:0] encode(input logic [TLB_ENTRIES-1:0] oh);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      if (oh[k]) idx = idx | IDX_W'(k);
    end
    return idx;
  endfunction

  // captured item
  logic [PAGE_BITS-1:0] vpn_r;
  logic                 write_r;
  logic [PAGE_BITS-1:0] walk_r;

  // entry state
  logic [TLB_ENTRIES-1:0] entry_valid;
  logic [TLB_ENTRIES-1:0] entry_used;
  logic [TLB_ENTRIES-1:0] entry_dirty;
  logic [PAGE_BITS-1:0]   entry_vpn [TLB_ENTRIES];
  logic [PAGE_BITS-1:0]   frame_mem [TLB_ENTRIES];
  logic [PAGE_BITS-1:0]   frame_rd;

  // registered search vectors
  logic [TLB_ENTRIES-1:0] match_r;
  logic [TLB_ENTRIES-1:0] inval_r;
  logic [TLB_ENTRIES-1:0] unused_r;

  logic [TLB_ENTRIES-1:0] match_oh;
  logic [TLB_ENTRIES-1:0] inval_oh;
  logic [TLB_ENTRIES-1:0] unused_oh;
  logic [TLB_ENTRIES-1:0] victim_oh;
  logic [TLB_ENTRIES-1:0] clear_mask;
  logic [TLB_ENTRIES-1:0] sel_oh;
  logic [IDX_W-1:0]       sel_idx;
  logic [IDX_W-1:0]       slot_r;
  logic                   hit_r;
  logic [tlbcr_pkg::HIT_W-1:0] hit_count;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vpn_r   <= vpn;
      write_r <= write;
      walk_r  <= walk_pfn;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      for (int k = 0; k < TLB_ENTRIES; k++) begin
        match_r[k] <= entry_valid[k] && (entry_vpn[k] == vpn_r);
      end
      inval_r  <= ~entry_valid;
      unused_r <= ~entry_used;
    end
  end

  // lowest set bit of each search vector
  always_comb begin
    match_oh  = match_r & (~match_r + ONE);
    inval_oh  = inval_r & (~inval_r + ONE);
    unused_oh = unused_r & (~unused_r + ONE);
    if (|inval_r) begin
      victim_oh  = inval_oh;
      clear_mask = '0;
    end else if (|unused_r) begin
      // sweep clears used bits ahead of the first unused entry
      victim_oh  = unused_oh;
      clear_mask = unused_oh - ONE;
    end else begin
      victim_oh  = ONE;
      clear_mask = '1;
    end
    sel_oh  = (|match_r) ? match_oh : victim_oh;
    sel_idx = encode(sel_oh);
  end

  assign status.hit = |match_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_used  <= '0;
      entry_dirty <= '0;
      hit_count   <= '0;
    end else if (cmd.read_mem) begin
      entry_used  <= entry_used | sel_oh;
      entry_dirty <= entry_dirty | (write_r ? sel_oh : '0);
      hit_count   <= hit_count + 1'b1;
    end else if (cmd.fill) begin
      entry_valid <= entry_valid | sel_oh;
      entry_used  <= (entry_used & ~clear_mask) | sel_oh;
      entry_dirty <= write_r ? (entry_dirty | sel_oh) : (entry_dirty & ~sel_oh);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      entry_vpn[sel_idx] <= vpn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      frame_mem[sel_idx] <= walk_r;
    end
    if (cmd.read_mem) begin
      frame_rd <= frame_mem[sel_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_mem || cmd.fill) begin
      slot_r <= sel_idx;
      hit_r  <= cmd.read_mem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pfn       <= tlbcr_pkg::PFN_W'({{tlbcr_pkg::PFN_W{1'b0}},
                                      (hit_r ? frame_rd : walk_r)});
      hit       <= hit_r;
      slot      <= tlbcr_pkg::SLOT_W'({{tlbcr_pkg::SLOT_W{1'b0}}, slot_r});
      hit_total <= hit_count;
    end
  end

endmodule

FILE: rtl/tlb_lookup_clock_replace_unit.sv
// Top level of the fully associative TLB with clock replacement.
//
//  Channel  Direction  Handshake             Payload
//  in       to unit    in_valid / in_stall   vpn, write, walk_pfn
//  out      from unit  out_valid / out_stall pfn, hit, slot, hit_total
//
// An accepted item passes input capture, the registered tag compare and search vectors,
// the frame read with the entry update, and the output register, then raises out_valid;
// the result transfers while out_stall is low, and the next item can be taken in the
// cycle after that transfer, so one item is finished before the next is taken.
// Reset (rst, synchronous) clears valid, used and dirty bits and the hit count.
// in_stall stays high from accept until the result transfer; a stalled result holds.
module tlb_lookup_clock_replace_unit #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_BITS   = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [PAGE_BITS-1:0]         vpn,
  input  logic                         write,
  input  logic [PAGE_BITS-1:0]         walk_pfn,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tlbcr_pkg::PFN_W-1:0]  pfn,
  output logic                         hit,
  output logic [tlbcr_pkg::SLOT_W-1:0] slot,
  output logic [tlbcr_pkg::HIT_W-1:0]  hit_total
);

  tlbcr_pkg::ctrl_cmd_t  cmd;
  tlbcr_pkg::dp_status_t status;

  tlbcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tlbcr_dp #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_BITS   (PAGE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .vpn       (vpn),
    .write     (write),
    .walk_pfn  (walk_pfn),
    .pfn       (pfn),
    .hit       (hit),
    .slot      (slot),
    .hit_total (hit_total)
  );

endmodule

FILE: rtl/tlbcr_checker.sv
// Port-level checker for the TLB unit, bound to the top level.
module tlbcr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tlbcr_pkg::PFN_W-1:0]  pfn,
  input logic                         hit,
  input logic [tlbcr_pkg::SLOT_W-1:0] slot,
  input logic [tlbcr_pkg::HIT_W-1:0]  hit_total
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pfn) && $stable(hit)
      && $stable(slot) && $stable(hit_total))
    else $error("stalled result changed");

  // every accepted item raises out_valid after the LOOK, SEL and LOAD states
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> ##4 out_valid)
    else $error("result missing after accept");

  // no new item while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // one result per item
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated");

endmodule

bind tlb_lookup_clock_replace_unit tlbcr_checker u_tlbcr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pfn       (pfn),
  .hit       (hit),
  .slot      (slot),
  .hit_total (hit_total)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the TLB lookup unit with clock replacement.
`timescale 1ns / 1ps

typedef struct packed {
  logic [19:0] pfn;
  logic        hit;
  logic [3:0]  slot;
  logic [31:0] hit_total;
} translation_t;

class tlb_scoreboard;
  localparam int ENTRIES = 16;

  bit          ent_valid [ENTRIES];
  logic [19:0] ent_tag   [ENTRIES];
  logic [19:0] ent_frame [ENTRIES];
  bit          ent_used  [ENTRIES];
  bit          ent_dirty [ENTRIES];
  logic [31:0] hit_count = '0;
  translation_t pending[$];
  int          errors;

  // Translate one accepted access and queue the result it must produce.
  function void note_access(logic [19:0] page, logic wr, logic [19:0] frame);
    translation_t res;
    int victim;
    bit done;
    victim = -1;
    for (int k = 0; k < ENTRIES; k++) begin
      if (victim < 0 && ent_valid[k] && ent_tag[k] == page) victim = k;
    end
    if (victim >= 0) begin
      ent_used[victim] = 1'b1;
      if (wr) ent_dirty[victim] = 1'b1;
      hit_count = hit_count + 32'd1;
      res.pfn = ent_frame[victim];
      res.hit = 1'b1;
    end else begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (victim < 0 && !ent_valid[k]) victim = k;
      end
      if (victim < 0) begin
        // Clock sweep: clear used bits until an unused entry shows up.
        done = 1'b0;
        victim = 0;
        for (int k = 0; k < ENTRIES; k++) begin
          if (!done) begin
            if (!ent_used[k]) begin
              victim = k;
              done = 1'b1;
            end else begin
              ent_used[k] = 1'b0;
            end
          end
        end
      end
      ent_valid[victim] = 1'b1;
      ent_tag[victim]   = page;
      ent_frame[victim] = frame;
      ent_used[victim]  = 1'b1;
      ent_dirty[victim] = wr;
      res.pfn = frame;
      res.hit = 1'b0;
    end
    res.slot      = victim[3:0];
    res.hit_total = hit_count;
    pending.push_back(res);
  endfunction

  task report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    errors++;
  endtask

  // Compare one transferred result against the oldest queued translation.
  task check_result(logic [19:0] pfn, logic hit, logic [3:0] slot, logic [31:0] total);
    translation_t want;
    if (pending.size() == 0) begin
      report_mismatch("unexpected result (pfn)", 0, pfn);
    end else begin
      want = pending.pop_front();
      if (pfn !== want.pfn) report_mismatch("pfn", want.pfn, pfn);
      if (hit !== want.hit) report_mismatch("hit", want.hit, hit);
      if (slot !== want.slot) report_mismatch("slot", want.slot, slot);
      if (total !== want.hit_total) report_mismatch("hit_total", want.hit_total, total);
    end
  endtask
endclass

module tb_top;

  localparam int  POOL_SIZE   = 24;
  localparam int  PHASE_ITEMS = 282;
  localparam int  CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [19:0] vpn;
  logic        write;
  logic [19:0] walk_pfn;
  logic        out_valid;
  logic        out_stall;
  logic [tlbcr_pkg::PFN_W-1:0]  pfn;
  logic                         hit;
  logic [tlbcr_pkg::SLOT_W-1:0] slot;
  logic [tlbcr_pkg::HIT_W-1:0]  hit_total;

  tlb_scoreboard sb;
  int          send_idle_pct;
  int          stall_pct;
  int          cycles;
  logic [19:0] page_pool [POOL_SIZE];

  tlb_lookup_clock_replace_unit #(
    .TLB_ENTRIES(16),
    .PAGE_BITS  (20)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .vpn      (vpn),
    .write    (write),
    .walk_pfn (walk_pfn),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pfn      (pfn),
    .hit      (hit),
    .slot     (slot),
    .hit_total(hit_total)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Check transfers, randomize the output stall and watch the cycle budget.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) sb.check_result(pfn, hit, slot, hit_total);
    out_stall <= ($urandom_range(99) < stall_pct);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** tlb_lookup_clock_replace_unit: FAILED **");
      $finish;
    end
  end

  // Offer one access, optionally after idle cycles, and hold it until transfer.
  task automatic push_item(input logic [19:0] page, input logic wr, input logic [19:0] frame);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    vpn      <= page;
    write    <= wr;
    walk_pfn <= frame;
    do @(posedge clk); while (in_stall);
    sb.note_access(page, wr, frame);
  endtask

  // Mostly recurring pages so hits and evictions both happen; some noise.
  task automatic run_random(input int count, input int idle_pct, input int hold_pct);
    logic [19:0] page;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 8) page_pool[$urandom_range(POOL_SIZE - 1)] = 20'($urandom);
      if ($urandom_range(99) < 80) page = page_pool[$urandom_range(POOL_SIZE - 1)];
      else page = 20'($urandom);
      push_item(page, 1'($urandom_range(1)), 20'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    vpn           = '0;
    write         = 1'b0;
    walk_pfn      = '0;
    out_stall     = 1'b0;
    cycles        = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int k = 0; k < POOL_SIZE; k++) page_pool[k] = 20'($urandom);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes of the fields, then hits with read and write.
    push_item(20'h00000, 1'b0, 20'h00000);
    push_item(20'hFFFFF, 1'b1, 20'hFFFFF);
    push_item(20'h00000, 1'b1, 20'h12345);
    push_item(20'hFFFFF, 1'b0, 20'h00000);
    // Fill the rest so every entry is valid and used.
    for (int k = 2; k < 16; k++) begin
      push_item(20'(20'h00100 + k), k[0], k[0] ? 20'hAAAAA : 20'h55555);
    end
    // All used: sweep clears every used bit and wraps to entry 0.
    push_item(20'h12345, 1'b0, 20'h0F0F0);
    // Partial sweep, hit on an entry with its used bit cleared, sticky dirty.
    push_item(20'h23456, 1'b1, 20'hF0F0F);
    push_item(20'h00102, 1'b1, 20'h11111);
    push_item(20'h00102, 1'b0, 20'h22222);
    push_item(20'h34567, 1'b0, 20'h33333);
    // Evicted page comes back as a miss.
    push_item(20'h00000, 1'b0, 20'h44444);

    run_random(PHASE_ITEMS, 0, 0);
    run_random(PHASE_ITEMS, 48, 0);
    run_random(PHASE_ITEMS, 0, 48);
    run_random(PHASE_ITEMS, 7, 7);
    in_valid <= 1'b0;
    stall_pct = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** tlb_lookup_clock_replace_unit: PASSED **");
    end else begin
      $display("** tlb_lookup_clock_replace_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tlbcr_pkg.sv
rtl/tlbcr_ctrl.sv
rtl/tlbcr_dp.sv
rtl/tlb_lookup_clock_replace_unit.sv
rtl/tlbcr_checker.sv
tb/tb_top.sv
